### src/mco_pkg.sv
// Shared constants and command/status types for the matrix chain cost block.
package mco_pkg;

  localparam int MAX_DIMS_DEF = 64;
  localparam int DIM_BITS_DEF = 16;
  localparam int DIM_IN_W     = 16;
  localparam int COST_W       = 64;

  typedef struct packed {
    logic load;
    logic latch_di;
    logic latch_dij;
    logic step;
    logic first;
    logic last;
    logic finish;
    logic short_chain;
  } mco_cmd_t;

  typedef struct packed {
    logic wr_done;
    logic out_busy;
  } mco_stat_t;

endpackage

### src/mco_dpath.sv
// Datapath: dimension store, cost table, split-point pipeline and result register.
module mco_dpath #(
  parameter int MAX_DIMS = mco_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS = mco_pkg::DIM_BITS_DEF,
  localparam int IW = $clog2(MAX_DIMS),
  localparam int CW = $clog2(MAX_DIMS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mco_pkg::mco_cmd_t             cmd_i,
  output mco_pkg::mco_stat_t            stat_o,
  output logic [CW-1:0]                 count_o,
  input  logic [IW-1:0]                 dim_raddr_i,
  input  logic [IW-1:0]                 idx_i_i,
  input  logic [IW-1:0]                 idx_j_i,
  input  logic [IW-1:0]                 idx_k_i,
  input  logic [mco_pkg::DIM_IN_W-1:0]  dim_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mco_pkg::COST_W-1:0]    min_cost_o,
  output logic                          cost_saturated_o,
  output logic                          chain_too_long_o
);
  import mco_pkg::*;

  localparam int PW = 3 * DIM_BITS;
  localparam int CD = 1 << (2 * IW);

  logic [DIM_BITS-1:0]   dim_mem [MAX_DIMS];
  logic [COST_W-1:0]     cost_mem [CD];

  logic [CW-1:0]         count_q;
  logic                  dropped_q;
  logic                  ovf_q;
  logic [DIM_BITS-1:0]   dim_in;
  logic [DIM_BITS-1:0]   dim_rd_q;
  logic [DIM_BITS-1:0]   di_q;
  logic [2*DIM_BITS-1:0] dij_q;

  logic                  v1_q, v2_q, v3_q;
  logic                  first1_q, first2_q, first3_q;
  logic                  last1_q, last2_q, last3_q;
  logic [COST_W-1:0]     ca_q, cb_q;
  logic [PW-1:0]         prod_d, prod_q;
  logic [COST_W:0]       ab_d, ab_q;
  logic [COST_W+1:0]     sum_d;
  logic [COST_W-1:0]     q_q;
  logic                  qovf_q;
  logic [COST_W-1:0]     best_q, best_d;
  logic                  wr_en;
  logic [IW-1:0]         k_nx;

  logic                  out_valid_q;
  logic [COST_W-1:0]     min_cost_q;
  logic                  sat_q;
  logic                  long_q;

  assign dim_in = DIM_BITS'(dim_value_i);
  assign k_nx   = IW'(idx_k_i + IW'(1));
  assign prod_d = dij_q * dim_rd_q;
  assign ab_d   = {1'b0, (first1_q ? '0 : ca_q)} + {1'b0, (last1_q ? '0 : cb_q)};
  assign sum_d  = {1'b0, ab_q} + (COST_W + 2)'(prod_q);
  assign best_d = (first3_q || (q_q < best_q)) ? q_q : best_q;
  assign wr_en  = v3_q && last3_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CW'(MAX_DIMS))) begin
      dim_mem[count_q[IW-1:0]] <= dim_in;
    end
    dim_rd_q <= dim_mem[dim_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cost_mem[{idx_i_i, idx_j_i}] <= best_d;
    end
    ca_q <= cost_mem[{idx_i_i, idx_k_i}];
    cb_q <= cost_mem[{k_nx, idx_j_i}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_di) begin
      di_q <= dim_rd_q;
    end
    if (cmd_i.latch_dij) begin
      dij_q <= di_q * dim_rd_q;
    end
    first1_q <= cmd_i.first;
    last1_q  <= cmd_i.last;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    first3_q <= first2_q;
    last3_q  <= last2_q;
    prod_q   <= prod_d;
    ab_q     <= ab_d;
    q_q      <= (sum_d[COST_W+1:COST_W] != 2'b00) ? '1 : sum_d[COST_W-1:0];
    qovf_q   <= (sum_d[COST_W+1:COST_W] != 2'b00);
    if (v3_q) begin
      best_q <= best_d;
    end
    if (cmd_i.finish) begin
      min_cost_q <= cmd_i.short_chain ? '0 : best_q;
      sat_q      <= cmd_i.short_chain ? 1'b0 : ovf_q;
      long_q     <= dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      count_q     <= '0;
      dropped_q   <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.step;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q && qovf_q) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.load) begin
        if (count_q < CW'(MAX_DIMS)) begin
          count_q <= CW'(count_q + CW'(1));
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q     <= '0;
        dropped_q   <= 1'b0;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_o          = count_q;
  assign stat_o.wr_done   = wr_en;
  assign stat_o.out_busy  = out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign min_cost_o       = min_cost_q;
  assign cost_saturated_o = sat_q;
  assign chain_too_long_o = long_q;

`ifndef ASSERT_OFF
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !out_valid_q)
    else $error("result overwritten while pending");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !(v1_q || v2_q || v3_q))
    else $error("item loaded during table fill");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && last3_q) |=> !v3_q)
    else $error("next interval started before write-back");
`endif

endmodule

### src/mco_ctrl.sv
// Controller: load, interval sequencing over the cost table, and result handoff.
module mco_ctrl #(
  parameter int MAX_DIMS = mco_pkg::MAX_DIMS_DEF,
  localparam int IW = $clog2(MAX_DIMS),
  localparam int CW = $clog2(MAX_DIMS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               last_dim_i,
  input  mco_pkg::mco_stat_t stat_i,
  input  logic [CW-1:0]      count_i,
  output mco_pkg::mco_cmd_t  cmd_o,
  output logic [IW-1:0]      dim_raddr_o,
  output logic [IW-1:0]      idx_i_o,
  output logic [IW-1:0]      idx_j_o,
  output logic [IW-1:0]      idx_k_o
);
  import mco_pkg::*;

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RDA    = 3'd2;
  localparam logic [2:0] S_RDB    = 3'd3;
  localparam logic [2:0] S_MULIJ  = 3'd4;
  localparam logic [2:0] S_RUN    = 3'd5;
  localparam logic [2:0] S_DRAIN  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] len_q, len_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] j;
  logic [CW-1:0] n_m1;
  logic          accept;
  logic          short_n;

  assign j       = IW'(i_q + len_q - IW'(1));
  assign n_m1    = CW'(count_i - CW'(1));
  assign short_n = count_i < CW'(3);
  assign accept  = in_valid_i && (state_q == S_LOAD);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    i_d         = i_q;
    k_d         = k_q;
    cmd_o       = '0;
    dim_raddr_o = k_q;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.load = accept;
        if (accept && last_dim_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        len_d = IW'(2);
        i_d   = IW'(1);
        state_d = short_n ? S_FINISH : S_RDA;
      end
      S_RDA: begin
        dim_raddr_o = IW'(i_q - IW'(1));
        state_d     = S_RDB;
      end
      S_RDB: begin
        dim_raddr_o    = j;
        cmd_o.latch_di = 1'b1;
        state_d        = S_MULIJ;
      end
      S_MULIJ: begin
        cmd_o.latch_dij = 1'b1;
        k_d             = i_q;
        state_d         = S_RUN;
      end
      S_RUN: begin
        cmd_o.step  = 1'b1;
        cmd_o.first = (k_q == i_q);
        cmd_o.last  = (IW'(k_q + IW'(1)) == j);
        k_d         = IW'(k_q + IW'(1));
        if (cmd_o.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat_i.wr_done) begin
          state_d = S_RDA;
          if (CW'(j) == n_m1) begin
            i_d = IW'(1);
            if (CW'(len_q) == n_m1) begin
              state_d = S_FINISH;
            end else begin
              len_d = IW'(len_q + IW'(1));
            end
          end else begin
            i_d = IW'(i_q + IW'(1));
          end
        end
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.finish      = 1'b1;
          cmd_o.short_chain = short_n;
          state_d           = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      len_q   <= '0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  assign in_stall_o = (state_q != S_LOAD);
  assign idx_i_o    = i_q;
  assign idx_j_o    = j;
  assign idx_k_o    = k_q;

`ifndef ASSERT_OFF
  a_step_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> (k_q < j) && (i_q != '0))
    else $error("split point outside interval");
  a_run_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && cmd_o.last) |=> state_q == S_DRAIN)
    else $error("interval not drained");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && last_dim_i) |=> in_stall_o)
    else $error("input open after end of chain");
`endif

endmodule

### src/matrix_chain_order_cost.sv
// Top level of the matrix chain minimum multiplication cost block.
// Dimensions enter one item per cycle; the item marked last starts the table fill,
// and one result item follows. For a chain of n stored dimensions the fill handles,
// per interval of length L (L = 2 .. n-1, n-L intervals each), a fetch of the outer
// dimensions, the L-1 split points through the split-point pipeline, and the write
// back of the minimum. The fill time is set by the one shared multiply/add/compare
// pipeline and the single pair of cost table reads per cycle. Chains of fewer than
// three dimensions skip the fill and finish with a cost of 0. The tables need no
// clearing pass after reset. Input is stalled from the last item until its result is
// loaded into the output register; that register holds the result until it is taken.
module matrix_chain_order_cost #(
  parameter int MAX_DIMS = mco_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS = mco_pkg::DIM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mco_pkg::DIM_IN_W-1:0] dim_value_i,
  input  logic                         last_dim_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mco_pkg::COST_W-1:0]   min_cost_o,
  output logic                         cost_saturated_o,
  output logic                         chain_too_long_o
);
  import mco_pkg::*;

  localparam int IW = $clog2(MAX_DIMS);
  localparam int CW = $clog2(MAX_DIMS + 1);

  mco_cmd_t      cmd;
  mco_stat_t     stat;
  logic [CW-1:0] count;
  logic [IW-1:0] dim_raddr;
  logic [IW-1:0] idx_i;
  logic [IW-1:0] idx_j;
  logic [IW-1:0] idx_k;

  mco_ctrl #(
    .MAX_DIMS(MAX_DIMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_dim_i  (last_dim_i),
    .stat_i      (stat),
    .count_i     (count),
    .cmd_o       (cmd),
    .dim_raddr_o (dim_raddr),
    .idx_i_o     (idx_i),
    .idx_j_o     (idx_j),
    .idx_k_o     (idx_k)
  );

  mco_dpath #(
    .MAX_DIMS(MAX_DIMS),
    .DIM_BITS(DIM_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .count_o          (count),
    .dim_raddr_i      (dim_raddr),
    .idx_i_i          (idx_i),
    .idx_j_i          (idx_j),
    .idx_k_i          (idx_k),
    .dim_value_i      (dim_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .min_cost_o       (min_cost_o),
    .cost_saturated_o (cost_saturated_o),
    .chain_too_long_o (chain_too_long_o)
  );

endmodule
